// ===== sv/sfl_pkg.sv =====
// Package for the segregated free-list allocator: constants, codes, types and helpers.
// No dependencies; every other file of the block but sfl_chan_if refers to it by scoped names.
package sfl_pkg;

  localparam int unsigned HEAP_BYTES  = 65536;
  localparam int unsigned CHUNK_BYTES = 4096;
  localparam int unsigned HEAP_WORDS  = HEAP_BYTES / 4;
  localparam int unsigned WORD_AW     = $clog2(HEAP_WORDS);
  localparam int unsigned TOP_W       = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned CLASS_COUNT = 10;
  localparam int unsigned CLASS_W     = $clog2(CLASS_COUNT);
  localparam int unsigned MIN_BLOCK   = 24;
  localparam int unsigned WALK_LIMIT  = HEAP_BYTES / 8;
  localparam int unsigned STEP_W      = $clog2(WALK_LIMIT + 1);

  // Operation codes
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;

  // Status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] request_size;
    logic [15:0] block_address;
  } sfl_item_t;

  typedef struct packed {
    logic [15:0] result_address;
    logic [1:0]  status;
  } sfl_result_t;

  // One heap memory access: read when en and not we, write when en and we
  typedef struct packed {
    logic        en;
    logic        we;
    logic [31:0] addr;
    logic [31:0] wdata;
  } sfl_mem_req_t;

  typedef enum logic [5:0] {
    S_IDLE, S_DEC, S_FIN,
    S_FR1, S_FR2,
    S_INIT0, S_INIT1, S_INIT2, S_INIT3,
    S_GR0, S_GR1, S_GR2, S_GR3,
    S_MG0, S_MG1, S_MG2, S_MG3,
    S_MG_C1A, S_MG_C1B, S_MG_C1C,
    S_MG_C2A, S_MG_C2B, S_MG_C2C, S_MG_C2D,
    S_MG_C3A, S_MG_C3B, S_MG_C3C, S_MG_C3D, S_MG_C3E, S_MG_C3F,
    S_MG_PUSH,
    S_PU0, S_PU1, S_PU2, S_PU3,
    S_RM0, S_RM1, S_RM2, S_RM3, S_RM4,
    S_FF0, S_FF_CHK, S_FF1, S_FF2,
    S_PL1, S_PL2, S_PL3, S_PL4, S_PL5, S_PL6, S_PL7
  } sfl_state_e;

  // Size class: below 16, then one class per power of two from 16 up, last open
  function automatic logic [CLASS_W-1:0] class_of(input logic [31:0] s);
    logic [CLASS_W-1:0] c;
    c = '0;
    if (s >= 32'd16) begin
      c = CLASS_W'(1);
      for (int i = 0; i < 8; i++) begin
        if (s >= (32'd32 << i)) c = CLASS_W'(i + 2);
      end
    end
    return c;
  endfunction

  // Heap growth rounds the word count up to an even number
  function automatic logic [31:0] grow_size(input logic [31:0] bytes);
    logic [31:0] w;
    w = bytes >> 2;
    return (w + {31'd0, w[0]}) << 2;
  endfunction

endpackage

// ===== sv/sfl_chan_if.sv =====
// Channel interfaces of the allocator: request and response with valid/ready.
// Depends on nothing but plain logic types.
interface sfl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] request_size;
  logic [15:0] block_address;
  modport source (output valid, operation, request_size, block_address, input ready);
  modport sink (input valid, operation, request_size, block_address, output ready);
endinterface

interface sfl_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_address;
  logic [1:0]  status;
  modport source (output valid, result_address, status, input ready);
  modport sink (input valid, result_address, status, output ready);
endinterface

// ===== sv/sfl_heap_mem.sv =====
// Heap word memory: one port, registered read, byte addressed.
// Depends on sfl_pkg. Addresses beyond the heap read as zero and drop writes.
module sfl_heap_mem (
  input  logic                  clk_i,
  input  sfl_pkg::sfl_mem_req_t mreq_i,
  output logic [31:0]           rdata_o
);

  logic [31:0] mem_q [sfl_pkg::HEAP_WORDS];
  logic [31:0] rdata_q;
  logic        in_range, in_range_q;
  logic [sfl_pkg::WORD_AW-1:0] widx;

  assign in_range = mreq_i.addr < 32'(sfl_pkg::HEAP_BYTES);
  assign widx     = mreq_i.addr[sfl_pkg::WORD_AW+1:2];

  // Write or read one word
  always_ff @(posedge clk_i) begin
    if (mreq_i.en && in_range) begin
      if (mreq_i.we) mem_q[widx] <= mreq_i.wdata;
      else rdata_q <= mem_q[widx];
    end
    if (mreq_i.en && !mreq_i.we) in_range_q <= in_range;
  end

  assign rdata_o = in_range_q ? rdata_q : 32'd0;

endmodule

// ===== sv/sfl_seq.sv =====
// Allocator sequencer: walks lists and updates boundary tags through the heap memory.
// Depends on sfl_pkg; drives the single port of sfl_heap_mem.
module sfl_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  sfl_pkg::sfl_item_t    item_i,
  output logic                  busy_o,
  input  logic                  res_ready_i,
  output logic                  done_o,
  output sfl_pkg::sfl_result_t  res_o,
  output sfl_pkg::sfl_mem_req_t mreq_o,
  input  logic [31:0]           rdata_i
);

  sfl_pkg::sfl_state_e st_q, st_d, ret_mg_q, ret_mg_d, ret_rm_q, ret_rm_d;
  sfl_pkg::sfl_state_e ret_pu_q, ret_pu_d;
  logic [31:0] heads_q [sfl_pkg::CLASS_COUNT];
  logic [31:0] heads_d [sfl_pkg::CLASS_COUNT];
  logic [sfl_pkg::TOP_W-1:0] top_q, top_d;

  sfl_pkg::sfl_item_t item_q, item_d;
  logic [31:0] bp_q, bp_d, size_q, size_d, nb_q, nb_d, pb_q, pb_d;
  logic [31:0] need_q, need_d, have_q, have_d, x_q, x_d, p_q, p_d, s_q, s_d;
  logic [31:0] cur_q, cur_d;
  logic [sfl_pkg::STEP_W-1:0]  steps_q, steps_d;
  logic [sfl_pkg::CLASS_W-1:0] cls_q, cls_d, fc_q, fc_d;
  logic        pu_q, pu_d;
  logic [15:0] res_q, res_d;
  logic [1:0]  stat_q, stat_d;

  logic [31:0] rd_sz, top32, addr32, ext, rest;

  assign rd_sz  = {rdata_i[31:3], 3'b000};
  assign top32  = 32'(top_q);
  assign addr32 = 32'(item_q.block_address);
  assign ext    = (need_q > 32'(sfl_pkg::CHUNK_BYTES)) ? need_q : 32'(sfl_pkg::CHUNK_BYTES);
  assign rest   = have_q - need_q;

  assign busy_o = st_q != sfl_pkg::S_IDLE;
  assign res_o  = '{result_address: res_q, status: stat_q};

  // Next state, memory access and register updates
  always_comb begin
    st_d = st_q; ret_mg_d = ret_mg_q; ret_rm_d = ret_rm_q; ret_pu_d = ret_pu_q;
    heads_d = heads_q; top_d = top_q; item_d = item_q;
    bp_d = bp_q; size_d = size_q; nb_d = nb_q; pb_d = pb_q; need_d = need_q;
    have_d = have_q; x_d = x_q; p_d = p_q; s_d = s_q; cur_d = cur_q;
    steps_d = steps_q; cls_d = cls_q; fc_d = fc_q; pu_d = pu_q;
    res_d = res_q; stat_d = stat_q;
    mreq_o = '0;
    done_o = 1'b0;
    case (st_q)
      sfl_pkg::S_IDLE: begin
        if (start_i) begin
          item_d = item_i;
          st_d = sfl_pkg::S_DEC;
        end
      end
      sfl_pkg::S_DEC: begin
        res_d = '0;
        stat_d = sfl_pkg::ST_DONE;
        if (item_q.operation == sfl_pkg::OP_INIT) begin
          st_d = sfl_pkg::S_INIT0;
        end else if (item_q.operation == sfl_pkg::OP_ALLOC) begin
          if (item_q.request_size == 16'd0) begin
            stat_d = sfl_pkg::ST_ZERO;
            st_d = sfl_pkg::S_FIN;
          end else if (top_q == '0) begin
            stat_d = sfl_pkg::ST_FULL;
            st_d = sfl_pkg::S_FIN;
          end else begin
            need_d = (item_q.request_size <= 16'd16) ? 32'(sfl_pkg::MIN_BLOCK)
                   : ((32'(item_q.request_size) + 32'd15) & ~32'd7);
            st_d = sfl_pkg::S_FF0;
          end
        end else if (addr32[2:0] == 3'd0 && addr32 >= 32'd16 && addr32 < top32) begin
          mreq_o = '{en: 1'b1, we: 1'b0, addr: addr32 - 32'd4, wdata: '0};
          st_d = sfl_pkg::S_FR1;
        end else begin
          st_d = sfl_pkg::S_FIN;
        end
      end
      // Free: clear the allocated bit in both tags, then merge
      sfl_pkg::S_FR1: begin
        size_d = rd_sz;
        mreq_o = '{en: 1'b1, we: 1'b1, addr: addr32 - 32'd4, wdata: rd_sz};
        st_d = sfl_pkg::S_FR2;
      end
      sfl_pkg::S_FR2: begin
        mreq_o = '{en: 1'b1, we: 1'b1, addr: addr32 + size_q - 32'd8, wdata: size_q};
        bp_d = addr32;
        ret_mg_d = sfl_pkg::S_FIN;
        st_d = sfl_pkg::S_MG0;
      end
      // Initialise: padding, prologue, epilogue
      sfl_pkg::S_INIT0: begin
        for (int i = 0; i < sfl_pkg::CLASS_COUNT; i++) heads_d[i] = '0;
        top_d = sfl_pkg::TOP_W'(16);
        mreq_o = '{en: 1'b1, we: 1'b1, addr: 32'd0, wdata: 32'd0};
        st_d = sfl_pkg::S_INIT1;
      end
      sfl_pkg::S_INIT1: begin
        mreq_o = '{en: 1'b1, we: 1'b1, addr: 32'd4, wdata: 32'd9};
        st_d = sfl_pkg::S_INIT2;
      end
      sfl_pkg::S_INIT2: begin
        mreq_o = '{en: 1'b1, we: 1'b1, addr: 32'd8, wdata: 32'd9};
        st_d = sfl_pkg::S_INIT3;
      end
      sfl_pkg::S_INIT3: begin
        mreq_o = '{en: 1'b1, we: 1'b1, addr: 32'd12, wdata: 32'd1};
        size_d = sfl_pkg::grow_size(32'(sfl_pkg::CHUNK_BYTES));
        st_d = sfl_pkg::S_GR0;
      end
      // Grow the heap by size_q
      sfl_pkg::S_GR0: begin
        if (top32 + size_q > 32'(sfl_pkg::HEAP_BYTES)) begin
          stat_d = sfl_pkg::ST_FULL;
          res_d = '0;
          st_d = sfl_pkg::S_FIN;
        end else begin
          bp_d = top32;
          top_d = top_q + size_q[sfl_pkg::TOP_W-1:0];
          mreq_o = '{en: 1'b1, we: 1'b1, addr: top32 - 32'd4, wdata: size_q};
          st_d = sfl_pkg::S_GR1;
        end
      end
      sfl_pkg::S_GR1: begin
        mreq_o = '{en: 1'b1, we: 1'b1, addr: bp_q + size_q - 32'd8, wdata: size_q};
        st_d = sfl_pkg::S_GR2;
      end
      sfl_pkg::S_GR2: begin
        mreq_o = '{en: 1'b1, we: 1'b1, addr: bp_q + size_q - 32'd4, wdata: 32'd1};
        ret_mg_d = sfl_pkg::S_GR3;
        st_d = sfl_pkg::S_MG0;
      end
      sfl_pkg::S_GR3: begin
        if (item_q.operation == sfl_pkg::OP_INIT) begin
          st_d = sfl_pkg::S_FIN;
        end else begin
          mreq_o = '{en: 1'b1, we: 1'b0, addr: bp_q - 32'd4, wdata: '0};
          st_d = sfl_pkg::S_PL1;
        end
      end
      // Merge: look at both neighbours
      sfl_pkg::S_MG0: begin
        mreq_o = '{en: 1'b1, we: 1'b0, addr: bp_q - 32'd8, wdata: '0};
        st_d = sfl_pkg::S_MG1;
      end
      sfl_pkg::S_MG1: begin
        pu_d = rdata_i[0];
        pb_d = bp_q - rd_sz;
        mreq_o = '{en: 1'b1, we: 1'b0, addr: bp_q - 32'd4, wdata: '0};
        st_d = sfl_pkg::S_MG2;
      end
      sfl_pkg::S_MG2: begin
        size_d = rd_sz;
        nb_d = bp_q + rd_sz;
        mreq_o = '{en: 1'b1, we: 1'b0, addr: bp_q + rd_sz - 32'd4, wdata: '0};
        st_d = sfl_pkg::S_MG3;
      end
      sfl_pkg::S_MG3: begin
        if (pu_q && !rdata_i[0]) begin
          x_d = nb_q; ret_rm_d = sfl_pkg::S_MG_C1A; st_d = sfl_pkg::S_RM0;
        end else if (!pu_q && rdata_i[0]) begin
          x_d = pb_q; ret_rm_d = sfl_pkg::S_MG_C2A; st_d = sfl_pkg::S_RM0;
        end else if (!pu_q && !rdata_i[0]) begin
          x_d = nb_q; ret_rm_d = sfl_pkg::S_MG_C3A; st_d = sfl_pkg::S_RM0;
        end else begin
          st_d = sfl_pkg::S_MG_PUSH;
        end
      end
      // Next block free
      sfl_pkg::S_MG_C1A: begin
        mreq_o = '{en: 1'b1, we: 1'b0, addr: nb_q - 32'd4, wdata: '0};
        st_d = sfl_pkg::S_MG_C1B;
      end
      sfl_pkg::S_MG_C1B: begin
        size_d = size_q + rd_sz;
        mreq_o = '{en: 1'b1, we: 1'b1, addr: bp_q - 32'd4, wdata: size_q + rd_sz};
        st_d = sfl_pkg::S_MG_C1C;
      end
      sfl_pkg::S_MG_C1C: begin
        mreq_o = '{en: 1'b1, we: 1'b1, addr: bp_q + size_q - 32'd8, wdata: size_q};
        st_d = sfl_pkg::S_MG_PUSH;
      end
      // Previous block free
      sfl_pkg::S_MG_C2A: begin
        mreq_o = '{en: 1'b1, we: 1'b0, addr: pb_q - 32'd4, wdata: '0};
        st_d = sfl_pkg::S_MG_C2B;
      end
      sfl_pkg::S_MG_C2B: begin
        size_d = size_q + rd_sz;
        mreq_o = '{en: 1'b1, we: 1'b0, addr: bp_q - 32'd4, wdata: '0};
        st_d = sfl_pkg::S_MG_C2C;
      end
      sfl_pkg::S_MG_C2C: begin
        mreq_o = '{en: 1'b1, we: 1'b1, addr: bp_q + rd_sz - 32'd8, wdata: size_q};
        st_d = sfl_pkg::S_MG_C2D;
      end
      sfl_pkg::S_MG_C2D: begin
        mreq_o = '{en: 1'b1, we: 1'b1, addr: pb_q - 32'd4, wdata: size_q};
        bp_d = pb_q;
        st_d = sfl_pkg::S_MG_PUSH;
      end
      // Both neighbours free: next was unlinked, now the previous one
      sfl_pkg::S_MG_C3A: begin
        x_d = pb_q;
        ret_rm_d = sfl_pkg::S_MG_C3B;
        st_d = sfl_pkg::S_RM0;
      end
      sfl_pkg::S_MG_C3B: begin
        mreq_o = '{en: 1'b1, we: 1'b0, addr: pb_q - 32'd4, wdata: '0};
        st_d = sfl_pkg::S_MG_C3C;
      end
      sfl_pkg::S_MG_C3C: begin
        size_d = size_q + rd_sz;
        mreq_o = '{en: 1'b1, we: 1'b0, addr: nb_q - 32'd4, wdata: '0};
        st_d = sfl_pkg::S_MG_C3D;
      end
      sfl_pkg::S_MG_C3D: begin
        size_d = size_q + rd_sz;
        mreq_o = '{en: 1'b1, we: 1'b1, addr: pb_q - 32'd4, wdata: size_q + rd_sz};
        st_d = sfl_pkg::S_MG_C3E;
      end
      sfl_pkg::S_MG_C3E: begin
        mreq_o = '{en: 1'b1, we: 1'b0, addr: nb_q - 32'd4, wdata: '0};
        st_d = sfl_pkg::S_MG_C3F;
      end
      sfl_pkg::S_MG_C3F: begin
        mreq_o = '{en: 1'b1, we: 1'b1, addr: nb_q + rd_sz - 32'd8, wdata: size_q};
        bp_d = pb_q;
        st_d = sfl_pkg::S_MG_PUSH;
      end
      sfl_pkg::S_MG_PUSH: begin
        x_d = bp_q;
        ret_pu_d = ret_mg_q;
        st_d = sfl_pkg::S_PU0;
      end
      // Push x_q at the head of its class list
      sfl_pkg::S_PU0: begin
        mreq_o = '{en: 1'b1, we: 1'b0, addr: x_q - 32'd4, wdata: '0};
        st_d = sfl_pkg::S_PU1;
      end
      sfl_pkg::S_PU1: begin
        cls_d = sfl_pkg::class_of(rd_sz);
        mreq_o = '{en: 1'b1, we: 1'b1, addr: x_q, wdata: 32'd0};
        st_d = sfl_pkg::S_PU2;
      end
      sfl_pkg::S_PU2: begin
        mreq_o = '{en: 1'b1, we: 1'b1, addr: x_q + 32'd8, wdata: heads_q[cls_q]};
        st_d = sfl_pkg::S_PU3;
      end
      sfl_pkg::S_PU3: begin
        if (heads_q[cls_q] != 32'd0) begin
          mreq_o = '{en: 1'b1, we: 1'b1, addr: heads_q[cls_q], wdata: x_q};
        end
        heads_d[cls_q] = x_q;
        st_d = ret_pu_q;
      end
      // Unlink x_q from its class list
      sfl_pkg::S_RM0: begin
        mreq_o = '{en: 1'b1, we: 1'b0, addr: x_q - 32'd4, wdata: '0};
        st_d = sfl_pkg::S_RM1;
      end
      sfl_pkg::S_RM1: begin
        cls_d = sfl_pkg::class_of(rd_sz);
        mreq_o = '{en: 1'b1, we: 1'b0, addr: x_q, wdata: '0};
        st_d = sfl_pkg::S_RM2;
      end
      sfl_pkg::S_RM2: begin
        p_d = rdata_i;
        mreq_o = '{en: 1'b1, we: 1'b0, addr: x_q + 32'd8, wdata: '0};
        st_d = sfl_pkg::S_RM3;
      end
      sfl_pkg::S_RM3: begin
        s_d = rdata_i;
        if (p_q == 32'd0) begin
          heads_d[cls_q] = rdata_i;
          if (rdata_i != 32'd0) mreq_o = '{en: 1'b1, we: 1'b1, addr: rdata_i, wdata: 32'd0};
          st_d = ret_rm_q;
        end else begin
          mreq_o = '{en: 1'b1, we: 1'b1, addr: p_q + 32'd8, wdata: rdata_i};
          st_d = sfl_pkg::S_RM4;
        end
      end
      sfl_pkg::S_RM4: begin
        if (s_q != 32'd0) mreq_o = '{en: 1'b1, we: 1'b1, addr: s_q, wdata: p_q};
        st_d = ret_rm_q;
      end
      // First fit, from the class of need upward
      sfl_pkg::S_FF0: begin
        fc_d = sfl_pkg::class_of(need_q);
        cur_d = heads_q[sfl_pkg::class_of(need_q)];
        steps_d = '0;
        st_d = sfl_pkg::S_FF_CHK;
      end
      sfl_pkg::S_FF_CHK: begin
        if (cur_q != 32'd0 && steps_q < sfl_pkg::STEP_W'(sfl_pkg::WALK_LIMIT)) begin
          mreq_o = '{en: 1'b1, we: 1'b0, addr: cur_q - 32'd4, wdata: '0};
          st_d = sfl_pkg::S_FF1;
        end else if (fc_q == sfl_pkg::CLASS_W'(sfl_pkg::CLASS_COUNT - 1)) begin
          size_d = sfl_pkg::grow_size(ext);
          st_d = sfl_pkg::S_GR0;
        end else begin
          fc_d = fc_q + sfl_pkg::CLASS_W'(1);
          cur_d = heads_q[fc_q + sfl_pkg::CLASS_W'(1)];
          steps_d = '0;
        end
      end
      sfl_pkg::S_FF1: begin
        if (rd_sz > need_q) begin
          bp_d = cur_q;
          mreq_o = '{en: 1'b1, we: 1'b0, addr: cur_q - 32'd4, wdata: '0};
          st_d = sfl_pkg::S_PL1;
        end else begin
          mreq_o = '{en: 1'b1, we: 1'b0, addr: cur_q + 32'd8, wdata: '0};
          st_d = sfl_pkg::S_FF2;
        end
      end
      sfl_pkg::S_FF2: begin
        cur_d = rdata_i;
        steps_d = steps_q + sfl_pkg::STEP_W'(1);
        st_d = sfl_pkg::S_FF_CHK;
      end
      // Place: unlink, then split or take whole
      sfl_pkg::S_PL1: begin
        have_d = rd_sz;
        x_d = bp_q;
        ret_rm_d = sfl_pkg::S_PL2;
        st_d = sfl_pkg::S_RM0;
      end
      sfl_pkg::S_PL2: begin
        res_d = bp_q[15:0];
        if (rest >= 32'(sfl_pkg::MIN_BLOCK)) begin
          mreq_o = '{en: 1'b1, we: 1'b1, addr: bp_q - 32'd4, wdata: need_q | 32'd1};
          st_d = sfl_pkg::S_PL3;
        end else begin
          mreq_o = '{en: 1'b1, we: 1'b1, addr: bp_q - 32'd4, wdata: have_q | 32'd1};
          st_d = sfl_pkg::S_PL6;
        end
      end
      sfl_pkg::S_PL3: begin
        mreq_o = '{en: 1'b1, we: 1'b1, addr: bp_q + need_q - 32'd8, wdata: need_q | 32'd1};
        st_d = sfl_pkg::S_PL4;
      end
      sfl_pkg::S_PL4: begin
        mreq_o = '{en: 1'b1, we: 1'b0, addr: bp_q - 32'd4, wdata: '0};
        st_d = sfl_pkg::S_PL5;
      end
      sfl_pkg::S_PL5: begin
        x_d = bp_q + rd_sz;
        mreq_o = '{en: 1'b1, we: 1'b1, addr: bp_q + rd_sz - 32'd4, wdata: rest};
        st_d = sfl_pkg::S_PL7;
      end
      sfl_pkg::S_PL7: begin
        mreq_o = '{en: 1'b1, we: 1'b1, addr: x_q + rest - 32'd8, wdata: rest};
        ret_pu_d = sfl_pkg::S_FIN;
        st_d = sfl_pkg::S_PU0;
      end
      sfl_pkg::S_PL6: begin
        mreq_o = '{en: 1'b1, we: 1'b1, addr: bp_q + have_q - 32'd8, wdata: have_q | 32'd1};
        st_d = sfl_pkg::S_FIN;
      end
      sfl_pkg::S_FIN: begin
        if (res_ready_i) begin
          done_o = 1'b1;
          st_d = sfl_pkg::S_IDLE;
        end
      end
      default: st_d = sfl_pkg::S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sfl_pkg::S_IDLE;
      ret_mg_q <= sfl_pkg::S_FIN;
      ret_rm_q <= sfl_pkg::S_FIN;
      ret_pu_q <= sfl_pkg::S_FIN;
      top_q <= '0;
      for (int i = 0; i < sfl_pkg::CLASS_COUNT; i++) heads_q[i] <= '0;
    end else begin
      st_q <= st_d;
      ret_mg_q <= ret_mg_d;
      ret_rm_q <= ret_rm_d;
      ret_pu_q <= ret_pu_d;
      top_q <= top_d;
      heads_q <= heads_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d; bp_q <= bp_d; size_q <= size_d; nb_q <= nb_d; pb_q <= pb_d;
    need_q <= need_d; have_q <= have_d; x_q <= x_d; p_q <= p_d; s_q <= s_d;
    cur_q <= cur_d; steps_q <= steps_d; cls_q <= cls_d; fc_q <= fc_d; pu_q <= pu_d;
    res_q <= res_d; stat_q <= stat_d;
  end

  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(top_q) <= 32'(sfl_pkg::HEAP_BYTES))
    else $error("heap top beyond capacity");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> st_q == sfl_pkg::S_IDLE)
    else $error("transaction started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> st_q == sfl_pkg::S_IDLE)
    else $error("sequencer not idle after result");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == sfl_pkg::S_FF1 |-> 32'(steps_q) < 32'(sfl_pkg::WALK_LIMIT))
    else $error("list walk past its limit");

endmodule

// ===== sv/segregated_free_list_allocator_top.sv =====
// A free or init walks no list; an allocate also walks the class lists, node by node.
// Each state makes at most one heap memory access on the single port, whose read is registered.
// One transaction at a time; the next is taken while the last result waits in its register.
// Reset clears the class heads and heap top at once; heap words stay undefined until written.
// Files: sfl_pkg, sfl_chan_if, sfl_heap_mem, sfl_seq.
module segregated_free_list_allocator_top (
  input logic       clk_i,
  input logic       rst_ni,
  sfl_req_if.sink   req_i,
  sfl_rsp_if.source rsp_o
);

  sfl_pkg::sfl_mem_req_t mreq;
  sfl_pkg::sfl_item_t    item;
  sfl_pkg::sfl_result_t  res, res_q;
  logic [31:0] rdata;
  logic busy, start, done, res_ready, valid_q;

  assign req_i.ready = !busy;
  assign start = req_i.valid && !busy;
  assign item = '{operation: req_i.operation, request_size: req_i.request_size,
                  block_address: req_i.block_address};
  assign res_ready = !valid_q || rsp_o.ready;

  sfl_heap_mem u_mem (.clk_i, .mreq_i(mreq), .rdata_o(rdata));

  sfl_seq u_seq (
    .clk_i, .rst_ni, .start_i(start), .item_i(item), .busy_o(busy),
    .res_ready_i(res_ready), .done_o(done), .res_o(res), .mreq_o(mreq), .rdata_i(rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (done) begin
      valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) res_q <= res;
  end

  assign rsp_o.valid = valid_q;
  assign rsp_o.result_address = res_q.result_address;
  assign rsp_o.status = res_q.status;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for segregated_free_list_allocator_top: directed, then random traffic.
// Depends on sfl_pkg and the channel interfaces in sfl_chan_if; predicts every result itself.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_FREE     = 2'd2;
  localparam logic [1:0] OP_FREE_ALT = 2'd3;
  localparam int unsigned IDLE_LIMIT = 200000;
  localparam int unsigned N_RANDOM   = 1200;

  logic clk_i;
  logic rst_ni;

  sfl_req_if req ();
  sfl_rsp_if rsp ();

  segregated_free_list_allocator_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req.sink),
    .rsp_o  (rsp.source)
  );

  // Predicted allocator state
  logic [31:0] heap_mem [sfl_pkg::HEAP_WORDS];
  logic [31:0] free_heads [sfl_pkg::CLASS_COUNT];
  logic [31:0] brk;

  // Stimulus and expected results
  sfl_pkg::sfl_item_t   pend_q [$];
  logic                 pend_drain_q [$];
  sfl_pkg::sfl_result_t pend_res_q [$];
  sfl_pkg::sfl_result_t want_q [$];
  logic [31:0]          live_blocks [$];

  int unsigned n_sent, n_got, idle_cycles;
  bit          failed;

  function automatic logic [31:0] hp_rd(input logic [31:0] a);
    return ((a >> 2) < sfl_pkg::HEAP_WORDS) ? heap_mem[a >> 2] : 32'd0;
  endfunction

  function automatic void hp_wr(input logic [31:0] a, input logic [31:0] v);
    if ((a >> 2) < sfl_pkg::HEAP_WORDS) heap_mem[a >> 2] = v;
  endfunction

  function automatic logic [31:0] size_at(input logic [31:0] tag_addr);
    return hp_rd(tag_addr) & ~32'd7;
  endfunction

  function automatic logic [31:0] bsize(input logic [31:0] bp);
    return size_at(bp - 32'd4);
  endfunction

  function automatic void write_tags(input logic [31:0] bp, input logic [31:0] sz,
                                     input logic [31:0] used);
    hp_wr(bp - 32'd4, sz | used);
    hp_wr(bp + sz - 32'd8, sz | used);
  endfunction

  function automatic int unsigned size_class(input logic [31:0] s);
    int unsigned c;
    logic [31:0] t;
    c = 1;
    t = 32;
    if (s < 16) return 0;
    while (c < 9 && s >= t) begin
      c++;
      t = t << 1;
    end
    return c;
  endfunction

  function automatic void link_in(input logic [31:0] bp);
    int unsigned c;
    logic [31:0] head;
    c = size_class(bsize(bp));
    head = free_heads[c];
    hp_wr(bp, 32'd0);
    hp_wr(bp + 32'd8, head);
    if (head != 0) hp_wr(head, bp);
    free_heads[c] = bp;
  endfunction

  function automatic void unlink(input logic [31:0] bp);
    int unsigned c;
    logic [31:0] p, s;
    c = size_class(bsize(bp));
    p = hp_rd(bp);
    s = hp_rd(bp + 32'd8);
    if (p == 0) begin
      free_heads[c] = s;
      if (s != 0) hp_wr(s, 32'd0);
    end else begin
      hp_wr(p + 32'd8, s);
      if (s != 0) hp_wr(s, p);
    end
  endfunction

  // Coalesce with free neighbors, then push the result on its list
  function automatic logic [31:0] coalesce(input logic [31:0] bp_in);
    logic [31:0] bp, nb, pb, sz;
    logic prev_used, next_used;
    bp = bp_in;
    prev_used = (hp_rd(bp - 32'd8) & 32'd1) != 32'd0;
    nb = bp + bsize(bp);
    next_used = (hp_rd(nb - 32'd4) & 32'd1) != 32'd0;
    sz = bsize(bp);
    if (prev_used && !next_used) begin
      unlink(nb);
      sz += bsize(nb);
      write_tags(bp, sz, 32'd0);
    end else if (!prev_used && next_used) begin
      pb = bp - size_at(bp - 32'd8);
      unlink(pb);
      sz += bsize(pb);
      hp_wr(bp + bsize(bp) - 32'd8, sz);
      hp_wr(pb - 32'd4, sz);
      bp = pb;
    end else if (!prev_used && !next_used) begin
      pb = bp - size_at(bp - 32'd8);
      unlink(nb);
      unlink(pb);
      sz += bsize(pb) + bsize(nb);
      hp_wr(pb - 32'd4, sz);
      hp_wr(nb + bsize(nb) - 32'd8, sz);
      bp = pb;
    end
    link_in(bp);
    return bp;
  endfunction

  function automatic logic [31:0] grow_heap(input logic [31:0] words);
    logic [31:0] sz, bp;
    sz = (words + (words & 32'd1)) * 32'd4;
    bp = brk;
    if (64'(brk) + 64'(sz) > 64'(sfl_pkg::HEAP_BYTES)) return 32'd0;
    brk += sz;
    write_tags(bp, sz, 32'd0);
    hp_wr(bp + sz - 32'd4, 32'd1);
    return coalesce(bp);
  endfunction

  function automatic logic [31:0] first_fit(input logic [31:0] need);
    logic [31:0] cur;
    int unsigned steps;
    for (int unsigned c = size_class(need); c < sfl_pkg::CLASS_COUNT; c++) begin
      cur = free_heads[c];
      steps = 0;
      while (cur != 0 && steps < sfl_pkg::WALK_LIMIT) begin
        if (bsize(cur) > need) return cur;
        cur = hp_rd(cur + 32'd8);
        steps++;
      end
    end
    return 32'd0;
  endfunction

  function automatic void carve(input logic [31:0] bp, input logic [31:0] need);
    logic [31:0] have, rest;
    have = bsize(bp);
    unlink(bp);
    if (have - need >= sfl_pkg::MIN_BLOCK) begin
      write_tags(bp, need, 32'd1);
      rest = bp + bsize(bp);
      write_tags(rest, have - need, 32'd0);
      link_in(rest);
    end else begin
      write_tags(bp, have, 32'd1);
    end
  endfunction

  // Apply one request to the predicted heap and return its response
  function automatic sfl_pkg::sfl_result_t alloc_predict(input sfl_pkg::sfl_item_t it);
    sfl_pkg::sfl_result_t r;
    logic [31:0] req_sz, addr, need, bp, ext;
    r = '0;
    req_sz = 32'(it.request_size);
    addr = 32'(it.block_address);
    if (it.operation == sfl_pkg::OP_INIT) begin
      foreach (free_heads[i]) free_heads[i] = 32'd0;
      brk = 32'd16;
      hp_wr(32'd0, 32'd0);
      hp_wr(32'd4, 32'd9);
      hp_wr(32'd8, 32'd9);
      hp_wr(32'd12, 32'd1);
      if (grow_heap(sfl_pkg::CHUNK_BYTES / 4) == 0) r.status = sfl_pkg::ST_FULL;
    end else if (it.operation == sfl_pkg::OP_ALLOC) begin
      if (req_sz == 0) r.status = sfl_pkg::ST_ZERO;
      else if (brk == 0) r.status = sfl_pkg::ST_FULL;
      else begin
        need = (req_sz <= 16) ? sfl_pkg::MIN_BLOCK : 32'd8 * ((req_sz + 32'd15) / 32'd8);
        bp = first_fit(need);
        if (bp == 0) begin
          ext = (need > sfl_pkg::CHUNK_BYTES) ? need : sfl_pkg::CHUNK_BYTES;
          bp = grow_heap(ext / 4);
        end
        if (bp == 0) r.status = sfl_pkg::ST_FULL;
        else begin
          carve(bp, need);
          r.result_address = bp[15:0];
        end
      end
    end else if (addr[2:0] == 3'd0 && addr >= 16 && addr < brk) begin
      write_tags(addr, bsize(addr), 32'd0);
      void'(coalesce(addr));
    end
    return r;
  endfunction

  // Queue one request with its predicted response; track live blocks
  task automatic add_item(input logic [1:0] op, input logic [15:0] sz,
                          input logic [15:0] addr, input logic drain = 1'b0);
    sfl_pkg::sfl_item_t it;
    sfl_pkg::sfl_result_t r;
    it.operation = op;
    it.request_size = sz;
    it.block_address = addr;
    r = alloc_predict(it);
    if (op == sfl_pkg::OP_INIT) live_blocks.delete();
    if (op == sfl_pkg::OP_ALLOC && r.result_address != 0)
      live_blocks.push_back(32'(r.result_address));
    pend_q.push_back(it);
    pend_res_q.push_back(r);
    pend_drain_q.push_back(drain);
  endtask

  // Free a live block chosen by index, removing it from the live set
  task automatic free_live(input int idx, input logic [1:0] op = OP_FREE);
    logic [31:0] a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    add_item(op, 16'($urandom), a[15:0]);
  endtask

  // Free request whose address is certain to be ignored
  task automatic add_ignored_free();
    logic [15:0] a;
    a = 16'($urandom);
    case ($urandom_range(0, 2))
      0: a[0] = 1'b1;
      1: a = 16'($urandom_range(0, 1) * 8);
      default: a = (brk >= 32'h10000) ? (a | 16'd1) : 16'($urandom_range(brk, 65535));
    endcase
    add_item($urandom_range(0, 1) ? OP_FREE : OP_FREE_ALT, 16'($urandom), a);
  endtask

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: presents queued requests with random gaps
  int unsigned gap_left;
  bit          no_gap_run;

  always @(posedge clk_i or negedge rst_ni) begin
    sfl_pkg::sfl_item_t nxt;
    bit accepted, go;
    int unsigned gap_n, sent_n;
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.operation <= sfl_pkg::OP_INIT;
      req.request_size <= '0;
      req.block_address <= '0;
      gap_left <= 0;
      n_sent <= 0;
      no_gap_run <= 1'b0;
    end else begin
      accepted = req.valid && req.ready;
      gap_n = gap_left;
      sent_n = n_sent;
      if (accepted) begin
        void'(pend_q.pop_front());
        void'(pend_drain_q.pop_front());
        want_q.push_back(pend_res_q.pop_front());
        sent_n++;
        gap_n = no_gap_run ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 63) == 0) no_gap_run <= ~no_gap_run;
      end
      if (req.valid && !accepted) begin
        go = 1'b1;
      end else if (gap_n > 0) begin
        gap_n--;
        go = 1'b0;
      end else begin
        go = pend_q.size() > 0;
        if (go && pend_drain_q[0] && (accepted || sent_n != n_got)) go = 1'b0;
      end
      if (go && !(req.valid && !accepted)) begin
        nxt = pend_q[0];
        req.operation <= nxt.operation;
        req.request_size <= nxt.request_size;
        req.block_address <= nxt.block_address;
      end
      req.valid <= go;
      gap_left <= gap_n;
      n_sent <= sent_n;
    end
  end

  // Monitor: random back-pressure and in-order comparison
  int unsigned stall_left;
  bit          no_stall_run;

  always @(posedge clk_i or negedge rst_ni) begin
    sfl_pkg::sfl_result_t exp_r;
    int unsigned s;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      stall_left <= 0;
      n_got <= 0;
      no_stall_run <= 1'b0;
    end else if (rsp.valid && rsp.ready) begin
      n_got <= n_got + 1;
      if (want_q.size() == 0) begin
        failed <= 1'b1;
        $display("%0t: unexpected transaction: expected none, actual addr=%0d status=%0d",
                 $time, rsp.result_address, rsp.status);
      end else begin
        exp_r = want_q.pop_front();
        if (rsp.result_address !== exp_r.result_address) begin
          failed <= 1'b1;
          $display("%0t: result_address mismatch: expected %0d, actual %0d",
                   $time, exp_r.result_address, rsp.result_address);
        end
        if (rsp.status !== exp_r.status) begin
          failed <= 1'b1;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, exp_r.status, rsp.status);
        end
      end
      s = no_stall_run ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 63) == 0) no_stall_run <= ~no_stall_run;
      rsp.ready <= (s == 0);
      stall_left <= s;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready <= (stall_left == 1);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned k, pick;
    logic [15:0] sz;
    brk = 32'd0;
    foreach (free_heads[i]) free_heads[i] = 32'd0;
    foreach (heap_mem[i]) heap_mem[i] = 32'd0;

    // Directed: before init, init, size extremes, ignored and merging frees
    add_item(sfl_pkg::OP_ALLOC, 16'd5, 16'd0);
    add_item(sfl_pkg::OP_ALLOC, 16'd0, 16'hFFFF);
    add_item(OP_FREE, 16'hFFFF, 16'd64);
    add_item(sfl_pkg::OP_INIT, 16'hFFFF, 16'hFFFF);
    add_item(sfl_pkg::OP_ALLOC, 16'd0, 16'd0);
    add_item(sfl_pkg::OP_ALLOC, 16'd1, 16'd0);
    add_item(sfl_pkg::OP_ALLOC, 16'd16, 16'd0);
    add_item(sfl_pkg::OP_ALLOC, 16'd17, 16'd0);
    add_item(sfl_pkg::OP_ALLOC, 16'd24, 16'd0);
    add_item(sfl_pkg::OP_ALLOC, 16'd4096, 16'd0);
    add_item(sfl_pkg::OP_ALLOC, 16'hFFFF, 16'd0);
    add_item(sfl_pkg::OP_ALLOC, 16'd4097, 16'd0);
    add_item(OP_FREE, 16'd0, 16'd33);
    add_item(OP_FREE, 16'd0, 16'd8);
    add_item(OP_FREE, 16'd0, 16'hFFF8);
    free_live(2);                     // neighbors used
    free_live(2);                     // previous free
    free_live(3);                     // next free
    free_live(2, OP_FREE_ALT);        // both free
    add_item(sfl_pkg::OP_ALLOC, 16'd40, 16'd0, 1'b1);
    add_item(sfl_pkg::OP_INIT, 16'd0, 16'd0);
    add_item(sfl_pkg::OP_ALLOC, 16'd60000, 16'd0);

    // Random: mostly allocate/free traffic, some noise and re-init
    for (k = 0; k < N_RANDOM; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        add_item(sfl_pkg::OP_INIT, 16'($urandom), 16'($urandom));
      end else if (pick < 8) begin
        add_ignored_free();
      end else if (pick < 52 && live_blocks.size() > 0) begin
        free_live($urandom_range(0, live_blocks.size() - 1),
                  $urandom_range(0, 4) == 0 ? OP_FREE_ALT : OP_FREE);
      end else begin
        case ($urandom_range(0, 19))
          0: sz = 16'($urandom);
          1: sz = 16'd0;
          2, 3: sz = 16'($urandom_range(1, 9000));
          default: sz = 16'($urandom_range(1, 300));
        endcase
        add_item(sfl_pkg::OP_ALLOC, sz, 16'($urandom), k % 400 == 399);
      end
    end

    wait (rst_ni === 1'b1);
    while (pend_q.size() > 0 || want_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (!failed && want_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
